/* rtl/core/lcrs_pkg.sv */
// ----------------------------------------------------------------------------
// lcrs_pkg
// Shared types, constants and helpers of the counting radix sort unit.
// ----------------------------------------------------------------------------
package lcrs_pkg;

  localparam int MAX_KEYS   = 64;
  localparam int DIGIT_BITS = 8;
  localparam int KEY_W      = 64;
  localparam int BUCKETS    = 1 << DIGIT_BITS;
  localparam int NUM_DIGITS = (KEY_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int IDX_W      = $clog2(MAX_KEYS);
  localparam int CNT_W      = $clog2(MAX_KEYS + 1);
  localparam int PASS_W     = $clog2(NUM_DIGITS + 1);

  typedef struct packed {
    logic [KEY_W-1:0] key_value;
    logic             end_of_set;
  } in_beat_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_value;
    logic             final_key;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLR,
    ST_CNT_RD,
    ST_CNT_HR,
    ST_CNT_WR,
    ST_PFX_RD,
    ST_PFX_WR,
    ST_SCT_RD,
    ST_SCT_OR,
    ST_SCT_WR,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WT
  } st_t;

  // digit selected by the pass number, optionally inverted
  function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [KEY_W-1:0] key,
                                                     input logic [PASS_W-1:0] pass,
                                                     input logic desc);
    logic [KEY_W-1:0] sh;
    begin
      sh = key >> (pass * DIGIT_BITS);
      digit_of = sh[DIGIT_BITS-1:0] ^ {DIGIT_BITS{desc}};
    end
  endfunction

  // passes = index of highest nonzero digit + 1, at least one
  function automatic logic [PASS_W-1:0] num_passes(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] sh;
    logic [PASS_W-1:0] p;
    begin
      p = PASS_W'(1);
      for (int d = 0; d < NUM_DIGITS; d++) begin
        sh = key >> (d * DIGIT_BITS);
        if (sh[DIGIT_BITS-1:0] != '0) begin
          p = PASS_W'(d + 1);
        end
      end
      num_passes = p;
    end
  endfunction

endpackage

/* rtl/core/lcrs_ram.sv */
// ----------------------------------------------------------------------------
// lcrs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lcrs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/lsd_counting_radix_sort_unit.sv */
// ----------------------------------------------------------------------------
// lsd_counting_radix_sort_unit
// Loads a set of 64-bit keys and streams them back in radix-sorted order.
// ----------------------------------------------------------------------------
// Input channel (in_*): one key per beat, one cycle each; end_of_set, or the
// 64th key, closes the set. in_ready is high only while loading.
// Sorting runs a small sequencer over one histogram RAM, one offset RAM and
// two ping-pong key RAMs. Each pass clears the histogram, counts every key's
// digit, forms the bucket offsets as a prefix sum and scatters the keys; the
// pass count is the number of 8-bit digits up to the top nonzero one of the
// largest key (1 to 8). Counting and scattering read each key from the registered-read
// key RAM, then read the key's bucket entry and write it back incremented.
// Output channel (out_*): one key per beat, final_key on the last; a new key
// is read only after the beat is taken. A stalled receiver holds the sequencer
// in its wait state with the beat unchanged. After the last beat loading resumes.
// cfg_* writes the descending bit; it is sampled when sorting starts.
// Reset (synchronous, rst_n low) returns to loading with an empty set.
// ----------------------------------------------------------------------------
module lsd_counting_radix_sort_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lcrs_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lcrs_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import lcrs_pkg::*;

  st_t               st_r, st_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [DIGIT_BITS-1:0] b_r, b_nxt;
  logic [PASS_W-1:0] pass_r, pass_nxt, passes_r, passes_nxt;
  logic [KEY_W-1:0]  max_r, max_nxt, key_r, key_nxt;
  logic [DIGIT_BITS-1:0] dig_r, dig_nxt;
  logic [CNT_W-1:0]  sum_r, sum_nxt;
  logic              sel_r, sel_nxt;
  logic              desc_r, desc_sort_r, desc_sort_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_r, out_nxt;

  logic              a_we, b_we;
  logic [IDX_W-1:0]  st_waddr;
  logic [KEY_W-1:0]  st_wdata, a_rd, b_rd, src_rd;
  logic              h_we, o_we;
  logic [DIGIT_BITS-1:0] h_waddr, h_raddr, o_waddr, o_raddr;
  logic [CNT_W-1:0]  h_wdata, h_rd, o_wdata, o_rd;
  logic [DIGIT_BITS-1:0] cur_dig;
  logic              in_acc, out_acc;
  logic [KEY_W-1:0]  new_max;

  lcrs_ram #(.DEPTH(MAX_KEYS), .WIDTH(KEY_W)) u_store_a (
    .clk, .we(a_we), .waddr(st_waddr), .wdata(st_wdata), .raddr(i_r), .rdata(a_rd));
  lcrs_ram #(.DEPTH(MAX_KEYS), .WIDTH(KEY_W)) u_store_b (
    .clk, .we(b_we), .waddr(st_waddr), .wdata(st_wdata), .raddr(i_r), .rdata(b_rd));
  lcrs_ram #(.DEPTH(BUCKETS), .WIDTH(CNT_W)) u_hist (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rd));
  lcrs_ram #(.DEPTH(BUCKETS), .WIDTH(CNT_W)) u_offs (
    .clk, .we(o_we), .waddr(o_waddr), .wdata(o_wdata), .raddr(o_raddr), .rdata(o_rd));

  assign in_ready  = (st_r == ST_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_acc   = out_valid_r && out_ready;
  assign cfg_ready = 1'b1;
  assign src_rd    = sel_r ? b_rd : a_rd;
  assign cur_dig   = digit_of(src_rd, pass_r, desc_sort_r);
  assign new_max   = (in_data.key_value > max_r) ? in_data.key_value : max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_LOAD;
      cnt_r       <= '0;
      max_r       <= '0;
      sel_r       <= 1'b0;
      desc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      max_r       <= max_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        desc_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    b_r         <= b_nxt;
    pass_r      <= pass_nxt;
    passes_r    <= passes_nxt;
    key_r       <= key_nxt;
    dig_r       <= dig_nxt;
    sum_r       <= sum_nxt;
    desc_sort_r <= desc_sort_nxt;
    out_r       <= out_nxt;
  end

  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    b_nxt         = b_r;
    pass_nxt      = pass_r;
    passes_nxt    = passes_r;
    max_nxt       = max_r;
    key_nxt       = key_r;
    dig_nxt       = dig_r;
    sum_nxt       = sum_r;
    sel_nxt       = sel_r;
    desc_sort_nxt = desc_sort_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    a_we          = 1'b0;
    b_we          = 1'b0;
    st_waddr      = cnt_r[IDX_W-1:0];
    st_wdata      = in_data.key_value;
    h_we          = 1'b0;
    h_waddr       = b_r;
    h_wdata       = '0;
    h_raddr       = b_r;
    o_we          = 1'b0;
    o_waddr       = b_r;
    o_wdata       = sum_r;
    o_raddr       = cur_dig;
    case (st_r)
      ST_LOAD: begin
        if (in_acc) begin
          a_we    = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          max_nxt = new_max;
          if (in_data.end_of_set || (cnt_r == CNT_W'(MAX_KEYS - 1))) begin
            passes_nxt    = num_passes(new_max);
            pass_nxt      = '0;
            b_nxt         = '0;
            i_nxt         = '0;
            desc_sort_nxt = desc_r;
            st_nxt        = ST_CLR;
          end
        end
      end
      ST_CLR: begin
        h_we  = 1'b1;
        b_nxt = b_r + DIGIT_BITS'(1);
        if (b_r == DIGIT_BITS'(BUCKETS - 1)) begin
          i_nxt  = '0;
          st_nxt = ST_CNT_RD;
        end
      end
      ST_CNT_RD: st_nxt = ST_CNT_HR;
      ST_CNT_HR: begin
        h_raddr = cur_dig;
        dig_nxt = cur_dig;
        st_nxt  = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        h_we    = 1'b1;
        h_waddr = dig_r;
        h_wdata = h_rd + CNT_W'(1);
        i_nxt   = i_r + IDX_W'(1);
        st_nxt  = ST_CNT_RD;
        if (CNT_W'(i_r) == cnt_r - CNT_W'(1)) begin
          b_nxt   = '0;
          sum_nxt = '0;
          st_nxt  = ST_PFX_RD;
        end
      end
      ST_PFX_RD: st_nxt = ST_PFX_WR;
      ST_PFX_WR: begin
        o_we    = 1'b1;
        sum_nxt = sum_r + h_rd;
        b_nxt   = b_r + DIGIT_BITS'(1);
        st_nxt  = ST_PFX_RD;
        if (b_r == DIGIT_BITS'(BUCKETS - 1)) begin
          i_nxt  = '0;
          st_nxt = ST_SCT_RD;
        end
      end
      ST_SCT_RD: st_nxt = ST_SCT_OR;
      ST_SCT_OR: begin
        key_nxt = src_rd;
        dig_nxt = cur_dig;
        st_nxt  = ST_SCT_WR;
      end
      ST_SCT_WR: begin
        // scatter into the other buffer and bump the bucket offset
        a_we     = sel_r;
        b_we     = !sel_r;
        st_waddr = o_rd[IDX_W-1:0];
        st_wdata = key_r;
        o_we     = 1'b1;
        o_waddr  = dig_r;
        o_wdata  = o_rd + CNT_W'(1);
        i_nxt    = i_r + IDX_W'(1);
        st_nxt   = ST_SCT_RD;
        if (CNT_W'(i_r) == cnt_r - CNT_W'(1)) begin
          sel_nxt  = !sel_r;
          pass_nxt = pass_r + PASS_W'(1);
          i_nxt    = '0;
          b_nxt    = '0;
          st_nxt   = (pass_r == passes_r - PASS_W'(1)) ? ST_EMIT_RD : ST_CLR;
        end
      end
      ST_EMIT_RD: st_nxt = ST_EMIT_LD;
      ST_EMIT_LD: begin
        out_nxt.sorted_value = src_rd;
        out_nxt.final_key    = (CNT_W'(i_r) == cnt_r - CNT_W'(1));
        out_valid_nxt        = 1'b1;
        st_nxt               = ST_EMIT_WT;
      end
      ST_EMIT_WT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          i_nxt         = i_r + IDX_W'(1);
          st_nxt        = ST_EMIT_RD;
          if (out_r.final_key) begin
            cnt_nxt = '0;
            max_nxt = '0;
            sel_nxt = 1'b0;
            st_nxt  = ST_LOAD;
          end
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output open at once");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_KEYS))
    else $error("key count beyond store depth");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled beat changed");

  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_data.final_key |=> in_ready && cnt_r == '0 && !sel_r)
    else $error("set not cleared after last beat");

endmodule
